// ===== hw/rtl/sawarq_pkg.sv =====
// Shared types and default values for the stop-and-wait ARQ sender.
package sawarq_pkg;

  localparam int unsigned SeqBitsDef = 32;

  localparam logic [15:0] TimeoutTicksRst  = 16'd1000;
  localparam logic [3:0]  MaxResendsRst    = 4'd6;
  localparam logic [15:0] TimeWaitTicksRst = 16'd2000;

  localparam logic [13:0] MaxLen = 14'd10000;

  // Configuration register indexes.
  localparam logic [1:0] CfgTimeoutTicks  = 2'd0;
  localparam logic [1:0] CfgMaxResends    = 2'd1;
  localparam logic [1:0] CfgTimeWaitTicks = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  rx_flags;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
    logic        rx_check_ok;
    logic [13:0] payload_length;
    logic        is_name;
  } event_t;

  typedef struct packed {
    logic        tx_send;
    logic [3:0]  tx_flags;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [13:0] tx_length;
    logic [2:0]  status;
  } result_t;

endpackage

// ===== hw/rtl/sawarq_core.sv =====
// Connection state, configuration registers and per-event next-state logic.
module sawarq_core #(
  parameter int unsigned SEQ_BITS = sawarq_pkg::SeqBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                step_i,
  input  sawarq_pkg::event_t  ev_i,
  output sawarq_pkg::result_t res_o
);

  localparam logic [3:0] PhIdle      = 4'd0;
  localparam logic [3:0] PhSynSent   = 4'd1;
  localparam logic [3:0] PhConnected = 4'd2;
  localparam logic [3:0] PhDataWait  = 4'd3;
  localparam logic [3:0] PhFinWait1  = 4'd4;
  localparam logic [3:0] PhFinWait2  = 4'd5;
  localparam logic [3:0] PhTimeWait  = 4'd6;
  localparam logic [3:0] PhClosed    = 4'd7;
  localparam logic [3:0] PhFailed    = 4'd8;

  localparam logic [2:0] ActOpen  = 3'd0;
  localparam logic [2:0] ActData  = 3'd1;
  localparam logic [2:0] ActClose = 3'd2;
  localparam logic [2:0] ActRx    = 3'd3;
  localparam logic [2:0] ActTick  = 3'd4;

  localparam logic [3:0] FlagSyn  = 4'h1;
  localparam logic [3:0] FlagAck  = 4'h2;
  localparam logic [3:0] FlagFin  = 4'h4;
  localparam logic [3:0] FlagName = 4'h8;

  localparam logic [2:0] StBusy      = 3'd0;
  localparam logic [2:0] StConnected = 3'd1;
  localparam logic [2:0] StAcked     = 3'd2;
  localparam logic [2:0] StClosed    = 3'd3;
  localparam logic [2:0] StFailed    = 3'd4;
  localparam logic [2:0] StIdle      = 3'd5;

  localparam logic [SEQ_BITS-1:0] SeqOne = {{(SEQ_BITS-1){1'b0}}, 1'b1};

  logic [15:0] timeout_ticks_q, linger_ticks_q;
  logic [3:0]  max_resends_q;

  logic [3:0]          phase_q, phase_d;
  logic [SEQ_BITS-1:0] seq_counter_q, seq_counter_d;
  logic [3:0]          last_flags_q, last_flags_d;
  logic [SEQ_BITS-1:0] last_seq_q, last_seq_d;
  logic [SEQ_BITS-1:0] last_ack_q, last_ack_d;
  logic [13:0]         last_length_q, last_length_d;
  logic [15:0]         wait_timer_q, wait_timer_d;
  logic [3:0]          resend_count_q, resend_count_d;

  logic [SEQ_BITS-1:0] rx_seq, rx_ack, seq_inc, last_next, rx_seq_inc;
  logic [13:0]         len_sat;
  logic [15:0]         timer_inc;
  logic                has_ack, has_syn, has_fin, ok, acked, emit;
  logic [31:0]         seq_ext, ack_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= sawarq_pkg::TimeoutTicksRst;
      max_resends_q   <= sawarq_pkg::MaxResendsRst;
      linger_ticks_q  <= sawarq_pkg::TimeWaitTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sawarq_pkg::CfgTimeoutTicks:  timeout_ticks_q <= cfg_data_i;
        sawarq_pkg::CfgMaxResends:    max_resends_q   <= cfg_data_i[3:0];
        sawarq_pkg::CfgTimeWaitTicks: linger_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rx_seq     = ev_i.rx_seq[SEQ_BITS-1:0];
  assign rx_ack     = ev_i.rx_ack[SEQ_BITS-1:0];
  assign seq_inc    = seq_counter_q + SeqOne;
  assign last_next  = last_seq_q + SeqOne;
  assign rx_seq_inc = rx_seq + SeqOne;
  assign len_sat    = (ev_i.payload_length > sawarq_pkg::MaxLen) ? sawarq_pkg::MaxLen
                                                                 : ev_i.payload_length;
  assign timer_inc  = (wait_timer_q != 16'hFFFF) ? wait_timer_q + 16'd1 : wait_timer_q;
  assign has_ack    = (ev_i.rx_flags & FlagAck) != 4'h0;
  assign has_syn    = (ev_i.rx_flags & FlagSyn) != 4'h0;
  assign has_fin    = (ev_i.rx_flags & FlagFin) != 4'h0;
  assign ok         = ev_i.rx_check_ok;

  always_comb begin
    phase_d        = phase_q;
    seq_counter_d  = seq_counter_q;
    last_flags_d   = last_flags_q;
    last_seq_d     = last_seq_q;
    last_ack_d     = last_ack_q;
    last_length_d  = last_length_q;
    wait_timer_d   = wait_timer_q;
    resend_count_d = resend_count_q;
    acked          = 1'b0;
    emit           = 1'b0;

    case (ev_i.action)
      ActOpen: begin
        if (phase_q == PhIdle || phase_q == PhClosed || phase_q == PhFailed) begin
          emit           = 1'b1;
          last_flags_d   = FlagSyn;
          last_seq_d     = seq_counter_q;
          last_ack_d     = '0;
          last_length_d  = '0;
          wait_timer_d   = '0;
          resend_count_d = '0;
          phase_d        = PhSynSent;
        end
      end
      ActData: begin
        if (phase_q == PhConnected) begin
          emit           = 1'b1;
          seq_counter_d  = seq_inc;
          last_flags_d   = ev_i.is_name ? FlagName : 4'h0;
          last_seq_d     = seq_inc;
          last_ack_d     = '0;
          last_length_d  = len_sat;
          wait_timer_d   = '0;
          resend_count_d = '0;
          phase_d        = PhDataWait;
        end
      end
      ActClose: begin
        if (phase_q == PhConnected) begin
          emit           = 1'b1;
          seq_counter_d  = seq_inc;
          last_flags_d   = FlagFin | FlagAck;
          last_seq_d     = seq_inc;
          last_ack_d     = '0;
          last_length_d  = '0;
          wait_timer_d   = '0;
          resend_count_d = '0;
          phase_d        = PhFinWait1;
        end
      end
      ActRx: begin
        case (phase_q)
          PhSynSent: begin
            if (has_ack && has_syn && ok && rx_ack == last_next) begin
              emit          = 1'b1;
              seq_counter_d = seq_inc;
              last_flags_d  = FlagAck;
              last_seq_d    = seq_inc;
              last_ack_d    = rx_seq_inc;
              last_length_d = '0;
              wait_timer_d  = '0;
              phase_d       = PhConnected;
            end
          end
          PhDataWait: begin
            if (has_ack && ok && rx_ack == last_seq_q) begin
              phase_d = PhConnected;
              acked   = 1'b1;
            end
          end
          PhFinWait1: begin
            if (has_ack && ok && rx_ack == last_next) begin
              phase_d      = PhFinWait2;
              wait_timer_d = '0;
            end
          end
          PhFinWait2: begin
            if (has_ack && has_fin && ok) begin
              emit          = 1'b1;
              seq_counter_d = seq_inc;
              last_flags_d  = FlagAck;
              last_seq_d    = seq_inc;
              last_ack_d    = rx_seq_inc;
              last_length_d = '0;
              wait_timer_d  = '0;
              phase_d       = PhTimeWait;
            end
          end
          PhTimeWait: emit = 1'b1;
          default: ;
        endcase
      end
      ActTick: begin
        if (phase_q == PhSynSent || phase_q == PhDataWait || phase_q == PhFinWait1) begin
          wait_timer_d = timer_inc;
          if (timer_inc >= timeout_ticks_q) begin
            if (resend_count_q >= max_resends_q) begin
              phase_d = PhFailed;
            end else begin
              resend_count_d = resend_count_q + 4'd1;
              emit           = 1'b1;
            end
            wait_timer_d = '0;
          end
        end else if (phase_q == PhTimeWait) begin
          wait_timer_d = timer_inc;
          if (timer_inc >= linger_ticks_q) begin
            phase_d      = PhClosed;
            wait_timer_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // The header fields always come from the updated last-sent copy.
  always_comb begin
    seq_ext                 = '0;
    ack_ext                 = '0;
    seq_ext[SEQ_BITS-1:0]   = last_seq_d;
    ack_ext[SEQ_BITS-1:0]   = last_ack_d;
    res_o                   = '0;
    if (emit) begin
      res_o.tx_send   = 1'b1;
      res_o.tx_flags  = last_flags_d;
      res_o.tx_seq    = seq_ext;
      res_o.tx_ack    = ack_ext;
      res_o.tx_length = last_length_d;
    end
    if (acked) begin
      res_o.status = StAcked;
    end else begin
      case (phase_d)
        PhIdle:      res_o.status = StIdle;
        PhConnected: res_o.status = StConnected;
        PhClosed:    res_o.status = StClosed;
        PhFailed:    res_o.status = StFailed;
        default:     res_o.status = StBusy;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhIdle;
      seq_counter_q  <= '0;
      last_flags_q   <= '0;
      last_seq_q     <= '0;
      last_ack_q     <= '0;
      last_length_q  <= '0;
      wait_timer_q   <= '0;
      resend_count_q <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      seq_counter_q  <= seq_counter_d;
      last_flags_q   <= last_flags_d;
      last_seq_q     <= last_seq_d;
      last_ack_q     <= last_ack_d;
      last_length_q  <= last_length_d;
      wait_timer_q   <= wait_timer_d;
      resend_count_q <= resend_count_d;
    end
  end

endmodule

// ===== hw/rtl/stop_and_wait_arq_sender_top.sv =====
// Stop-and-wait ARQ sender: input handshake, event engine and result register.
//
// Each input word is one event: open, send data, close, a received header
// or a timer tick. Every accepted word produces exactly one result word that
// says whether a header goes out now (with its flags, numbers and length)
// and the link status after the event.
// Both channels use valid and stall; a word moves on a rising edge with
// valid high and stall low. The result is held in a single register and
// appears in the cycle after its event is accepted. While the receiver does
// not stall, events are accepted at a sustained rate of one per cycle.
// When the receiver stalls, the held result stays put and the input side
// stalls in the same cycle; events keep flowing as soon as the register is
// free or is being emptied.
// Configuration registers (timeout, resend limit, time-wait length) are
// written by the user through a simple write port only while no event is in
// flight; the block does not enforce this. Reset puts the link in idle with
// sequence counter zero, clears the result register and restores the default config.
module stop_and_wait_arq_sender_top #(
  parameter int unsigned SEQ_BITS = sawarq_pkg::SeqBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [3:0]  rx_flags_i,
  input  logic [31:0] rx_seq_i,
  input  logic [31:0] rx_ack_i,
  input  logic        rx_check_ok_i,
  input  logic [13:0] payload_length_i,
  input  logic        is_name_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_send_o,
  output logic [3:0]  tx_flags_o,
  output logic [31:0] tx_seq_o,
  output logic [31:0] tx_ack_o,
  output logic [13:0] tx_length_o,
  output logic [2:0]  status_o
);

  sawarq_pkg::event_t  ev;
  sawarq_pkg::result_t res, res_q;
  logic                accept;
  logic                out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign ev.action         = action_i;
  assign ev.rx_flags       = rx_flags_i;
  assign ev.rx_seq         = rx_seq_i;
  assign ev.rx_ack         = rx_ack_i;
  assign ev.rx_check_ok    = rx_check_ok_i;
  assign ev.payload_length = payload_length_i;
  assign ev.is_name        = is_name_i;

  sawarq_core #(
    .SEQ_BITS(SEQ_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (accept),
    .ev_i        (ev),
    .res_o       (res)
  );

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_send_o   = res_q.tx_send;
  assign tx_flags_o  = res_q.tx_flags;
  assign tx_seq_o    = res_q.tx_seq;
  assign tx_ack_o    = res_q.tx_ack;
  assign tx_length_o = res_q.tx_length;
  assign status_o    = res_q.status;

endmodule
